// File: rtl/lcsw_pkg.sv
// ----------------------------------------------------------------------------
// Load-cell session weigher package
// Shared widths, constants and command types for the weigher and its units.
// ----------------------------------------------------------------------------
`default_nettype none

package lcsw_pkg;

  // Readings averaged to form the calibration baseline.
  localparam int CAL_SAMPLES     = 5;
  // Samples stored in one weighing session.
  localparam int SESSION_SAMPLES = 15;

  // Session result: skip the largest SKIP_N samples, average the next AVG_N.
  localparam int SKIP_N = 2;
  localparam int AVG_N  = 5;
  localparam int TOP_N  = SKIP_N + AVG_N;
  localparam int IDX_W  = $clog2(TOP_N);

  // Field widths.
  localparam int READ_W    = 25;
  localparam int Q4_W      = 24;
  localparam int GPC_W     = 32;
  localparam int GRAMS_W   = 16;
  localparam int LIMIT_W   = 8;
  localparam int CAL_SUM_W = 29;
  localparam int PROD_W    = READ_W + GPC_W;

  // Constant divider: dividend magnitude and rounded-up reciprocals. The
  // quotient is exact because the reciprocal error times any dividend below
  // 2^27 stays under 2^RCP_SH for every divisor up to 7.
  localparam int DIV_W  = 27;
  localparam int RCP_SH = 30;
  localparam int RCP_W  = 31;
  localparam logic [RCP_W-1:0] CAL_RCP =
      RCP_W'((2 ** RCP_SH + CAL_SAMPLES - 1) / CAL_SAMPLES);
  localparam logic [RCP_W-1:0] AVG_RCP =
      RCP_W'((2 ** RCP_SH + AVG_N - 1) / AVG_N);

  // Configuration register indexes.
  localparam logic [1:0] REG_GRAMS_PER_COUNT   = 2'd0;
  localparam logic [1:0] REG_TRIGGER_GRAMS     = 2'd1;
  localparam logic [1:0] REG_RECALIBRATE_GRAMS = 2'd2;
  localparam logic [1:0] REG_RECALIBRATE_LIMIT = 2'd3;

  // Result event codes.
  typedef enum logic [3:0] {
    EV_MISSING     = 4'd0,
    EV_CALIBRATING = 4'd1,
    EV_CAL_DONE    = 4'd2,
    EV_IDLE        = 4'd3,
    EV_START       = 4'd4,
    EV_SAMPLE      = 4'd5,
    EV_WEIGHT      = 4'd6,
    EV_LITTER      = 4'd7,
    EV_RECAL       = 4'd8
  } event_e;

  // Commands to the ranking unit.
  typedef struct packed {
    logic clear;
    logic insert;
    logic accumulate;
  } rank_cmd_t;

endpackage

`default_nettype wire

// File: rtl/load_cell_session_weigher_unit.sv
// ----------------------------------------------------------------------------
// Load-cell session weigher
// Calibrates a baseline, scales readings to 1/16 grams, detects weighing
// sessions and reports a cat weight or added litter at session end.
// ----------------------------------------------------------------------------
// Usage: one input beat carries a sensor-ready flag and a summed raw reading;
// every input beat yields exactly one output beat (event, weight, baseline).
// in_stall_o is high while an item is in work; the block takes one item at a
// time. States passed from accept until the block can accept again:
//   sensor missing or calibrating: EVAL, EMIT
//   calibrated reading, no session sample: EVAL, MUL, JUDGE, EMIT
//   calibration done: EVAL, DIV (reciprocal divide), EMIT
//   session sample: EVAL, MUL, JUDGE, INSERT (7-slot serial insertion), EMIT
//   session end: as a session sample, then SUM (5-step sum) and DIV
//                (reciprocal divide) before EMIT
// A result waits in the output register while out_stall_i is high; the next
// item is accepted meanwhile, and its result is held back until the register
// is free. Reset loads the default configuration and clears calibration,
// session and drift state. Configuration writes take effect at once; they are
// to be made only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module load_cell_session_weigher_unit
  import lcsw_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Configuration write port
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [GPC_W-1:0]  cfg_data_i,
  // Input channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              sensor_ready_i,
  input  wire logic signed [READ_W-1:0] total_reading_i,
  // Output channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [3:0]             event_res_o,
  output logic [Q4_W-1:0]        weight_q4_o,
  output logic signed [READ_W-1:0] baseline_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_JUDGE,
    ST_INSERT,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } state_e;

  localparam logic [LIMIT_W-1:0] DRIFT_MAX = '1;
  localparam logic [Q4_W-1:0]    Q4_MAX    = '1;

  // Configuration registers.
  logic [GPC_W-1:0]   gpc_q;
  logic [GRAMS_W-1:0] trig_q;
  logic [GRAMS_W-1:0] recal_q;
  logic [LIMIT_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpc_q   <= GPC_W'(10237484);
      trig_q  <= GRAMS_W'(1000);
      recal_q <= GRAMS_W'(30);
      limit_q <= LIMIT_W'(5);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GRAMS_PER_COUNT:   gpc_q   <= cfg_data_i;
        REG_TRIGGER_GRAMS:     trig_q  <= cfg_data_i[GRAMS_W-1:0];
        REG_RECALIBRATE_GRAMS: recal_q <= cfg_data_i[GRAMS_W-1:0];
        REG_RECALIBRATE_LIMIT: limit_q <= cfg_data_i[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state and working registers.
  state_e                  state_q, state_d;
  logic                    sr_q, sr_d;
  logic [READ_W-1:0]       rd_q, rd_d;
  logic                    calibrated_q, calibrated_d;
  logic [CAL_SUM_W-1:0]    cal_sum_q, cal_sum_d;
  logic [2:0]              cal_count_q, cal_count_d;
  logic [READ_W-1:0]       baseline_q, baseline_d;
  logic                    session_q, session_d;
  logic [3:0]              session_count_q, session_count_d;
  logic                    end_q, end_d;
  logic [LIMIT_W-1:0]      drift_q, drift_d;
  logic [READ_W-1:0]       mag_q, mag_d;
  logic                    inc_q, inc_d;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic                    div_cal_q, div_cal_d;
  logic                    cal_neg_q, cal_neg_d;
  event_e                  ev_q, ev_d;
  logic [Q4_W-1:0]         wq_q, wq_d;
  logic                    out_valid_q, out_valid_d;
  logic [3:0]              out_ev_q, out_ev_d;
  logic [Q4_W-1:0]         out_wq_q, out_wq_d;
  logic [READ_W-1:0]       out_bl_q, out_bl_d;

  // Shared unit controls; the rank unit takes the scaled sample of this cycle.
  rank_cmd_t        rank_cmd;
  logic             rank_busy;
  logic [DIV_W-1:0] rank_sum;
  logic [Q4_W-1:0]  q4;
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [RCP_W-1:0] div_recip;
  logic             div_busy;
  logic [DIV_W-1:0] div_quot;

  lcsw_rank u_rank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (rank_cmd),
    .value_i (q4),
    .busy_o  (rank_busy),
    .sum_o   (rank_sum)
  );

  lcsw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .recip_i    (div_recip),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // Calibration accumulation.
  logic [2:0]           cnt_nx;
  logic [CAL_SUM_W-1:0] sum_nx;
  logic [CAL_SUM_W-1:0] sum_abs;
  assign cnt_nx  = cal_count_q + 3'd1;
  assign sum_nx  = cal_sum_q + {{(CAL_SUM_W - READ_W){rd_q[READ_W-1]}}, rd_q};
  assign sum_abs = sum_nx[CAL_SUM_W-1] ? (CAL_SUM_W'(0) - sum_nx) : sum_nx;

  // Difference from the baseline and its magnitude.
  logic [READ_W:0] diff;
  logic [READ_W:0] diff_abs;
  assign diff     = {rd_q[READ_W-1], rd_q} - {baseline_q[READ_W-1], baseline_q};
  assign diff_abs = diff[READ_W] ? ((READ_W + 1)'(0) - diff) : diff;

  // Scaled weight and threshold tests on the registered product.
  logic [PROD_W-29:0]   w_full;
  logic [PROD_W-33:0]   p_hi;
  logic                 p_lo_nz;
  logic                 above_trig;
  logic                 above_recal;
  logic [3:0]           sc_nx;
  logic [LIMIT_W-1:0]   drift_nx;
  logic [Q4_W-1:0]      final_w;
  assign w_full      = prod_q[PROD_W-1:28];
  assign q4          = (|w_full[PROD_W-29:Q4_W]) ? Q4_MAX : w_full[Q4_W-1:0];
  assign p_hi        = prod_q[PROD_W-1:32];
  assign p_lo_nz     = |prod_q[31:0];
  assign above_trig  = (p_hi > (PROD_W - 32)'(trig_q)) ||
                       ((p_hi == (PROD_W - 32)'(trig_q)) && p_lo_nz);
  assign above_recal = (p_hi > (PROD_W - 32)'(recal_q)) ||
                       ((p_hi == (PROD_W - 32)'(recal_q)) && p_lo_nz);
  assign sc_nx       = session_count_q + 4'd1;
  assign drift_nx    = (drift_q == DRIFT_MAX) ? DRIFT_MAX : drift_q + 1'b1;
  assign final_w     = div_quot[Q4_W-1:0];

  // Next-state logic of the sequencer.
  always_comb begin
    state_d         = state_q;
    sr_d            = sr_q;
    rd_d            = rd_q;
    calibrated_d    = calibrated_q;
    cal_sum_d       = cal_sum_q;
    cal_count_d     = cal_count_q;
    baseline_d      = baseline_q;
    session_d       = session_q;
    session_count_d = session_count_q;
    end_d           = end_q;
    drift_d         = drift_q;
    mag_d           = mag_q;
    inc_d           = inc_q;
    prod_d          = prod_q;
    div_cal_d       = div_cal_q;
    cal_neg_d       = cal_neg_q;
    ev_d            = ev_q;
    wq_d            = wq_q;
    out_valid_d     = out_valid_q && out_stall_i;
    out_ev_d        = out_ev_q;
    out_wq_d        = out_wq_q;
    out_bl_d        = out_bl_q;
    rank_cmd        = '0;
    div_start       = 1'b0;
    div_dividend    = '0;
    div_recip       = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sr_d    = sensor_ready_i;
          rd_d    = total_reading_i;
          state_d = ST_EVAL;
        end
      end

      ST_EVAL: begin
        if (!sr_q) begin
          calibrated_d = 1'b0;
          cal_sum_d    = '0;
          cal_count_d  = '0;
          ev_d         = EV_MISSING;
          wq_d         = '0;
          state_d      = ST_EMIT;
        end else if (!calibrated_q) begin
          if (cnt_nx >= 3'(CAL_SAMPLES)) begin
            cal_neg_d    = sum_nx[CAL_SUM_W-1];
            div_start    = 1'b1;
            div_dividend = sum_abs[DIV_W-1:0];
            div_recip    = CAL_RCP;
            div_cal_d    = 1'b1;
            cal_sum_d    = '0;
            cal_count_d  = '0;
            state_d      = ST_DIV;
          end else begin
            cal_sum_d   = sum_nx;
            cal_count_d = cnt_nx;
            ev_d        = EV_CALIBRATING;
            wq_d        = '0;
            state_d     = ST_EMIT;
          end
        end else begin
          inc_d   = !diff[READ_W];
          mag_d   = diff_abs[READ_W-1:0];
          state_d = ST_MUL;
        end
      end

      ST_MUL: begin
        prod_d  = mag_q * gpc_q;
        state_d = ST_JUDGE;
      end

      ST_JUDGE: begin
        wq_d = q4;
        if (session_q) begin
          rank_cmd.insert = 1'b1;
          if (sc_nx >= 4'(SESSION_SAMPLES)) begin
            end_d           = 1'b1;
            session_d       = 1'b0;
            session_count_d = '0;
          end else begin
            end_d           = 1'b0;
            session_count_d = sc_nx;
          end
          state_d = ST_INSERT;
        end else if (inc_q && above_trig) begin
          session_d      = 1'b1;
          rank_cmd.clear = 1'b1;
          ev_d           = EV_START;
          state_d        = ST_EMIT;
        end else if (above_recal) begin
          drift_d = drift_nx;
          if (drift_nx > limit_q) begin
            calibrated_d = 1'b0;
            cal_sum_d    = '0;
            cal_count_d  = '0;
            ev_d         = EV_RECAL;
          end else begin
            ev_d = EV_IDLE;
          end
          state_d = ST_EMIT;
        end else begin
          ev_d    = EV_IDLE;
          state_d = ST_EMIT;
        end
      end

      // Wait for the insertion; at session end start the rank sum.
      ST_INSERT: begin
        if (!rank_busy) begin
          if (end_q) begin
            rank_cmd.accumulate = 1'b1;
            state_d             = ST_SUM;
          end else begin
            ev_d    = EV_SAMPLE;
            state_d = ST_EMIT;
          end
        end
      end

      ST_SUM: begin
        if (!rank_busy) begin
          div_start    = 1'b1;
          div_dividend = rank_sum;
          div_recip    = AVG_RCP;
          div_cal_d    = 1'b0;
          state_d      = ST_DIV;
        end
      end

      ST_DIV: begin
        if (!div_busy) begin
          if (div_cal_q) begin
            baseline_d   = cal_neg_q ? (READ_W'(0) - div_quot[READ_W-1:0])
                                     : div_quot[READ_W-1:0];
            calibrated_d = 1'b1;
            ev_d         = EV_CAL_DONE;
            wq_d         = '0;
          end else begin
            ev_d = (final_w > Q4_W'({trig_q, 4'b0000})) ? EV_WEIGHT : EV_LITTER;
            wq_d = final_w;
          end
          state_d = ST_EMIT;
        end
      end

      // Load the output register once it is free.
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_ev_d    = ev_q;
          out_wq_d    = wq_q;
          out_bl_d    = baseline_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      sr_q            <= 1'b0;
      rd_q            <= '0;
      calibrated_q    <= 1'b0;
      cal_sum_q       <= '0;
      cal_count_q     <= '0;
      baseline_q      <= '0;
      session_q       <= 1'b0;
      session_count_q <= '0;
      end_q           <= 1'b0;
      drift_q         <= '0;
      mag_q           <= '0;
      inc_q           <= 1'b0;
      prod_q          <= '0;
      div_cal_q       <= 1'b0;
      cal_neg_q       <= 1'b0;
      ev_q            <= EV_MISSING;
      wq_q            <= '0;
      out_valid_q     <= 1'b0;
      out_ev_q        <= '0;
      out_wq_q        <= '0;
      out_bl_q        <= '0;
    end else begin
      state_q         <= state_d;
      sr_q            <= sr_d;
      rd_q            <= rd_d;
      calibrated_q    <= calibrated_d;
      cal_sum_q       <= cal_sum_d;
      cal_count_q     <= cal_count_d;
      baseline_q      <= baseline_d;
      session_q       <= session_d;
      session_count_q <= session_count_d;
      end_q           <= end_d;
      drift_q         <= drift_d;
      mag_q           <= mag_d;
      inc_q           <= inc_d;
      prod_q          <= prod_d;
      div_cal_q       <= div_cal_d;
      cal_neg_q       <= cal_neg_d;
      ev_q            <= ev_d;
      wq_q            <= wq_d;
      out_valid_q     <= out_valid_d;
      out_ev_q        <= out_ev_d;
      out_wq_q        <= out_wq_d;
      out_bl_q        <= out_bl_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign event_res_o = out_ev_q;
  assign weight_q4_o = out_wq_q;
  assign baseline_o  = out_bl_q;

endmodule

`default_nettype wire

// File: rtl/lcsw_div.sv
// ----------------------------------------------------------------------------
// Constant divider
// Divides an unsigned magnitude by a small constant through multiplication
// with its rounded-up reciprocal; the operands and then the product are registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsw_div
  import lcsw_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [RCP_W-1:0] recip_i,
  output logic                  busy_o,
  output logic [DIV_W-1:0]      quot_o
);

  logic                     busy_q;
  logic [DIV_W-1:0]         dvd_q;
  logic [RCP_W-1:0]         rcp_q;
  logic [DIV_W+RCP_W-1:0]   prod_q;

  // Capture the operands at start, multiply on the following cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      dvd_q  <= '0;
      rcp_q  <= '0;
      prod_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      dvd_q  <= dividend_i;
      rcp_q  <= recip_i;
    end else if (busy_q) begin
      prod_q <= dvd_q * rcp_q;
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = prod_q[RCP_SH +: DIV_W];

endmodule

`default_nettype wire

// File: rtl/lcsw_rank.sv
// ----------------------------------------------------------------------------
// Session ranking unit
// Keeps the largest samples of a session in descending order with one
// shared comparator, and sums the ranks that make up the average.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsw_rank
  import lcsw_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rank_cmd_t       cmd_i,
  input  wire logic [Q4_W-1:0] value_i,
  output logic                 busy_o,
  output logic [DIV_W-1:0]     sum_o
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_INSERT,
    M_SUM
  } mode_e;

  mode_e            mode_q;
  logic [IDX_W-1:0] idx_q;
  logic [Q4_W-1:0]  carry_q;
  logic [DIV_W-1:0] acc_q;
  logic [Q4_W-1:0]  slot_q [TOP_N];

  // The single slot under the shared comparator this cycle.
  logic [Q4_W-1:0] cur;
  assign cur = slot_q[idx_q];

  // Insertion bubbles the carried sample down the list; the smallest drops out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      idx_q   <= '0;
      carry_q <= '0;
      acc_q   <= '0;
      for (int k = 0; k < TOP_N; k++) begin
        slot_q[k] <= '0;
      end
    end else begin
      if (cmd_i.clear) begin
        for (int k = 0; k < TOP_N; k++) begin
          slot_q[k] <= '0;
        end
      end
      case (mode_q)
        M_IDLE: begin
          if (cmd_i.insert) begin
            carry_q <= value_i;
            idx_q   <= '0;
            mode_q  <= M_INSERT;
          end else if (cmd_i.accumulate) begin
            acc_q  <= '0;
            idx_q  <= IDX_W'(SKIP_N);
            mode_q <= M_SUM;
          end
        end
        M_INSERT: begin
          if (carry_q > cur) begin
            slot_q[idx_q] <= carry_q;
            carry_q       <= cur;
          end
          if (idx_q == IDX_W'(TOP_N - 1)) begin
            mode_q <= M_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        M_SUM: begin
          acc_q <= acc_q + DIV_W'(cur);
          if (idx_q == IDX_W'(TOP_N - 1)) begin
            mode_q <= M_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        default: begin
          mode_q <= M_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (mode_q != M_IDLE);
  assign sum_o  = acc_q;

endmodule

`default_nettype wire

// File: bench/lcsw_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load-cell session weigher result checker
// Watches the configuration port and both channels of the weigher. Each
// accepted reading beat is run through a cycle-free model of the calibration,
// drift and session logic. Each result beat is compared field by field with the
// oldest predicted result. Failures, outstanding results and a few coverage
// counts are handed to the testbench top.
// ----------------------------------------------------------------------------
module lcsw_result_checker
  import lcsw_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration port, observed
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [GPC_W-1:0]         cfg_data_i,
  // Input channel, observed
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic                     sensor_ready_i,
  input  logic signed [READ_W-1:0] total_reading_i,
  // Output channel, observed
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [3:0]               event_res_i,
  input  logic [Q4_W-1:0]          weight_q4_i,
  input  logic signed [READ_W-1:0] baseline_i,
  // Status for the top
  output int unsigned              fail_count_o,
  output int unsigned              pending_o,
  output int unsigned              sessions_o,
  output int unsigned              recals_o
);

  localparam int unsigned MAX_REPORTS = 20;
  localparam longint unsigned Q4_MAX  = 64'hFF_FFFF;

  typedef struct packed {
    event_e                 ev;
    logic [Q4_W-1:0]        q4;
    logic signed [READ_W-1:0] base;
  } weigh_result_t;

  weigh_result_t expected_results[$];
  int unsigned   result_beats;

  // Shadow of the configuration registers.
  logic [GPC_W-1:0]   cfg_gpc;
  logic [GRAMS_W-1:0] cfg_trigger;
  logic [GRAMS_W-1:0] cfg_recal;
  logic [LIMIT_W-1:0] cfg_limit;

  // Shadow of the weigher state.
  bit              cal_done;
  longint          cal_acc;
  int              cal_seen;
  longint          base_counts;
  bit              in_session;
  int              session_fill;
  logic [Q4_W-1:0] session_q4 [SESSION_SAMPLES];
  int              drift_hits;

  function automatic void reset_weigher_model();
    cfg_gpc      = 32'd10237484;
    cfg_trigger  = 16'd1000;
    cfg_recal    = 16'd30;
    cfg_limit    = 8'd5;
    cal_done     = 1'b0;
    cal_acc      = 0;
    cal_seen     = 0;
    base_counts  = 0;
    in_session   = 1'b0;
    session_fill = 0;
    drift_hits   = 0;
    foreach (session_q4[k]) session_q4[k] = '0;
  endfunction

  // Sort the stored session weights from heaviest down, skip the heaviest few
  // and average the next ones.
  function automatic logic [Q4_W-1:0] session_average();
    logic [Q4_W-1:0] v [SESSION_SAMPLES];
    logic [Q4_W-1:0] t;
    int unsigned     acc;
    int              i;
    int              j;
    v = session_q4;
    for (i = 0; i < SESSION_SAMPLES; i++) begin
      for (j = i + 1; j < SESSION_SAMPLES; j++) begin
        if (v[j] > v[i]) begin
          t    = v[i];
          v[i] = v[j];
          v[j] = t;
        end
      end
    end
    acc = 0;
    for (i = SKIP_N; i < TOP_N && i < SESSION_SAMPLES; i++) acc += v[i];
    return Q4_W'(acc / AVG_N);
  endfunction

  // Advance the weigher state by one reading and return the result it gives.
  function automatic weigh_result_t weigh_reading(input logic ready,
                                                  input logic signed [READ_W-1:0] rd);
    weigh_result_t   r;
    longint          diff;
    longint unsigned mag;
    longint unsigned p;
    longint unsigned w;
    logic [Q4_W-1:0] q4;
    q4   = '0;
    r.ev = EV_IDLE;
    if (!ready) begin
      // Sensor missing: restart calibration, keep session and drift state.
      r.ev     = EV_MISSING;
      cal_done = 1'b0;
      cal_acc  = 0;
      cal_seen = 0;
    end else if (!cal_done) begin
      cal_seen++;
      cal_acc += rd;
      if (cal_seen >= CAL_SAMPLES) begin
        // Signed division truncates toward zero.
        base_counts = cal_acc / CAL_SAMPLES;
        cal_acc     = 0;
        cal_seen    = 0;
        cal_done    = 1'b1;
        r.ev        = EV_CAL_DONE;
      end else begin
        r.ev = EV_CALIBRATING;
      end
    end else begin
      diff = longint'(rd) - base_counts;
      mag  = (diff < 0) ? longint'(-diff) : diff;
      p    = mag * 64'(cfg_gpc);
      w    = p >> 28;
      q4   = (w > Q4_MAX) ? '1 : w[Q4_W-1:0];
      if (in_session) begin
        session_q4[session_fill] = q4;
        session_fill++;
        if (session_fill >= SESSION_SAMPLES) begin
          q4           = session_average();
          r.ev         = (32'(q4) > 32'(cfg_trigger) * 16) ? EV_WEIGHT : EV_LITTER;
          in_session   = 1'b0;
          session_fill = 0;
        end else begin
          r.ev = EV_SAMPLE;
        end
      end else if (diff >= 0 && p > (64'(cfg_trigger) << 32)) begin
        in_session = 1'b1;
        r.ev       = EV_START;
      end else if (p > (64'(cfg_recal) << 32)) begin
        // The drift counter saturates and is never cleared.
        if (drift_hits < 255) drift_hits++;
        if (drift_hits > int'(cfg_limit)) begin
          cal_seen = 0;
          cal_acc  = 0;
          cal_done = 1'b0;
          r.ev     = EV_RECAL;
        end
      end
    end
    if (r.ev inside {EV_MISSING, EV_CALIBRATING, EV_CAL_DONE}) q4 = '0;
    r.q4   = q4;
    r.base = base_counts[READ_W-1:0];
    return r;
  endfunction

  // Compare one result beat with the oldest prediction.
  function automatic void check_result_beat();
    weigh_result_t exp_r;
    result_beats++;
    if (expected_results.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= MAX_REPORTS)
        $display("%0t: result beat %0d with nothing expected: event %0d weight %0d baseline %0d",
                 $time, result_beats, event_res_i, weight_q4_i, baseline_i);
      return;
    end
    exp_r = expected_results.pop_front();
    if (event_res_i !== exp_r.ev || weight_q4_i !== exp_r.q4 || baseline_i !== exp_r.base) begin
      fail_count_o++;
      if (fail_count_o <= MAX_REPORTS)
        $display("%0t: result beat %0d: expected event %0d weight %0d baseline %0d, got event %0d weight %0d baseline %0d",
                 $time, result_beats, exp_r.ev, exp_r.q4, exp_r.base,
                 event_res_i, weight_q4_i, baseline_i);
    end
  endfunction

  // Register writes, result checks and predictions, in that order per edge.
  always @(posedge clk_i or negedge rst_ni) begin
    weigh_result_t r;
    if (!rst_ni) begin
      reset_weigher_model();
      expected_results.delete();
      result_beats = 0;
      fail_count_o = 0;
      pending_o    = 0;
      sessions_o   = 0;
      recals_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_GRAMS_PER_COUNT:   cfg_gpc     = cfg_data_i;
          REG_TRIGGER_GRAMS:     cfg_trigger = cfg_data_i[GRAMS_W-1:0];
          REG_RECALIBRATE_GRAMS: cfg_recal   = cfg_data_i[GRAMS_W-1:0];
          REG_RECALIBRATE_LIMIT: cfg_limit   = cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_result_beat();
      if (in_valid_i && !in_stall_i) begin
        r = weigh_reading(sensor_ready_i, total_reading_i);
        if (r.ev inside {EV_WEIGHT, EV_LITTER}) sessions_o++;
        if (r.ev == EV_RECAL) recals_o++;
        expected_results.push_back(r);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// File: bench/tb_load_cell_session_weigher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load-cell session weigher testbench
// Drives readings and sensor-missing beats into the weigher with random gaps
// and output back-pressure, across several register settings including both
// extremes. A directed opening covers calibration rounding, range extremes and
// a session interrupted by a missing sensor; random episodes then calibrate on
// a baseline and mix idle drift, weighing sessions, litter and noise. Checking
// is done by the checker module beside the block.
// ----------------------------------------------------------------------------
module tb_load_cell_session_weigher_unit;
  import lcsw_pkg::*;

  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     SETTLE_CYCLES  = 64;
  localparam longint READ_MIN       = -16777216;
  localparam longint READ_MAX       = 16777214;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [1:0]               cfg_index;
  logic [GPC_W-1:0]         cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic                     sensor_ready;
  logic signed [READ_W-1:0] total_reading;
  logic                     out_valid;
  logic                     out_stall;
  logic [3:0]               event_res;
  logic [Q4_W-1:0]          weight_q4;
  logic signed [READ_W-1:0] baseline;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sessions;
  int unsigned recals;

  bit               steady;
  int unsigned      items_sent;
  int unsigned      settings_used;
  int unsigned      quiet_cycles;
  logic [GPC_W-1:0] cur_gpc;
  longint unsigned  cur_trigger;
  longint unsigned  cur_recal;

  load_cell_session_weigher_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .sensor_ready_i  (sensor_ready),
    .total_reading_i (total_reading),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .event_res_o     (event_res),
    .weight_q4_o     (weight_q4),
    .baseline_o      (baseline)
  );

  lcsw_result_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .sensor_ready_i  (sensor_ready),
    .total_reading_i (total_reading),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .event_res_i     (event_res),
    .weight_q4_i     (weight_q4),
    .baseline_i      (baseline),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .sessions_o      (sessions),
    .recals_o        (recals)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver back-pressure, off during the steady stretch.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall <= !steady && ($urandom_range(99) < 36);
    end
  end

  // Watchdog on cycles in which no beat moves on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, pending);
        $display("tb_load_cell_session_weigher_unit NOT OK");
        $finish;
      end
    end
  end

  function automatic logic signed [READ_W-1:0] clamp_reading(input longint counts);
    if (counts > READ_MAX) return READ_W'(READ_MAX);
    if (counts < READ_MIN) return READ_W'(READ_MIN);
    return READ_W'(counts);
  endfunction

  function automatic longint rand_reading();
    return longint'($urandom_range(0, 33554430)) + READ_MIN;
  endfunction

  // Uniform offset in [-a, a].
  function automatic longint jitter(input longint a);
    longint m;
    m = (a > 16777215) ? 16777215 : ((a < 0) ? 0 : a);
    return longint'($urandom_range(0, 32'(2 * m))) - m;
  endfunction

  // Raw counts that make the given number of grams at the current scale.
  function automatic longint grams_to_counts(input longint unsigned grams);
    longint unsigned c;
    if (cur_gpc == 0) return 16777215;
    c = ((grams << 32) + 64'(cur_gpc) - 1) / 64'(cur_gpc);
    return (c > 16777215) ? 16777215 : longint'(c);
  endfunction

  // Send one reading beat; entered and left at a falling edge.
  task automatic send_reading(input logic ready, input longint counts);
    int gap;
    gap = 0;
    if (!steady) while ($urandom_range(99) < 36) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid      <= 1'b1;
    sensor_ready  <= ready;
    total_reading <= clamp_reading(counts);
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Hold off the sender until every predicted result has arrived.
  task automatic drain_results(input bit settle);
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write all four registers on consecutive cycles; junk fills the upper bits.
  task automatic set_config(input logic [GPC_W-1:0] gpc, input logic [GRAMS_W-1:0] trig,
                            input logic [GRAMS_W-1:0] recal, input logic [LIMIT_W-1:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GRAMS_PER_COUNT;
    cfg_data  <= gpc;
    @(negedge clk_i);
    cfg_index <= REG_TRIGGER_GRAMS;
    cfg_data  <= {16'($urandom), trig};
    @(negedge clk_i);
    cfg_index <= REG_RECALIBRATE_GRAMS;
    cfg_data  <= {16'($urandom), recal};
    @(negedge clk_i);
    cfg_index <= REG_RECALIBRATE_LIMIT;
    cfg_data  <= {24'($urandom), lim};
    @(negedge clk_i);
    cfg_we <= 1'b0;
    cur_gpc     = gpc;
    cur_trigger = trig;
    cur_recal   = recal;
    settings_used++;
  endtask

  // One episode: sensor dropout, calibration on a baseline, then a mix of
  // idle readings, drift, weighing sessions, litter sessions and noise.
  task automatic run_episode();
    longint base;
    longint trig_c;
    longint drift_c;
    longint cat;
    longint offs;
    int     steps;
    int     pick;
    bit     litter;
    if ($urandom_range(15) == 0) drain_results(1'b0);
    trig_c  = grams_to_counts(cur_trigger);
    drift_c = grams_to_counts(cur_recal);
    base    = longint'($urandom_range(0, 12000000)) - 6000000;
    send_reading(1'b0, rand_reading());
    repeat (CAL_SAMPLES) send_reading(1'b1, base + jitter(8));
    steps = $urandom_range(8, 40);
    repeat (steps) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_reading(1'($urandom_range(1)), rand_reading());
      end else if (pick < 22) begin
        cat    = trig_c + 1 + (trig_c * $urandom_range(10, 300)) / 100;
        litter = ($urandom_range(3) == 0);
        send_reading(1'b1, base + cat);
        repeat (SESSION_SAMPLES) begin
          if (litter) send_reading(1'b1, base + longint'($urandom_range(0, 32'(trig_c / 2))));
          else send_reading(1'b1, base + cat + jitter(cat / 20));
        end
      end else if (pick < 40) begin
        offs = drift_c + 1 + longint'($urandom_range(0, 32'(drift_c)));
        send_reading(1'b1, $urandom_range(1) ? base + offs : base - offs);
      end else begin
        send_reading(1'b1, base + jitter(drift_c / 2));
      end
    end
  endtask

  task automatic run_random(input int unsigned until_items);
    while (items_sent < until_items) run_episode();
  endtask

  // Stimulus and verdict.
  initial begin
    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_GRAMS_PER_COUNT;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    sensor_ready  <= 1'b0;
    total_reading <= '0;
    steady        = 1'b0;
    items_sent    = 0;
    settings_used = 1;
    cur_gpc       = 32'd10237484;
    cur_trigger   = 1000;
    cur_recal     = 30;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening at reset settings: missing sensor at the low extreme.
    send_reading(1'b0, READ_MIN);
    // Calibration over both range extremes; the mean is negative.
    send_reading(1'b1, READ_MAX);
    repeat (4) send_reading(1'b1, READ_MIN);
    // A large rise opens a session; samples span the whole range.
    send_reading(1'b1, READ_MAX);
    send_reading(1'b1, READ_MAX);
    send_reading(1'b1, 0);
    send_reading(1'b1, -1);
    send_reading(1'b1, 8388607);
    send_reading(1'b1, -8388608);
    send_reading(1'b1, READ_MAX);
    send_reading(1'b1, 12345678);
    // Sensor lost mid-session: calibration restarts, the session carries on.
    send_reading(1'b0, READ_MAX);
    repeat (4) send_reading(1'b1, -3);
    send_reading(1'b1, -2);
    send_reading(1'b1, 1678110);
    send_reading(1'b1, 1678200);
    send_reading(1'b1, 1677900);
    send_reading(1'b1, 1700000);
    send_reading(1'b1, 1650000);
    send_reading(1'b1, 1678000);
    send_reading(1'b1, 1690000);
    send_reading(1'b1, 1660000);
    run_random(330);

    // Every register at its maximum.
    drain_results(1'b1);
    set_config(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    run_random(580);

    // Every register at zero: nothing ever scales above zero grams.
    drain_results(1'b1);
    set_config(32'd0, 16'd0, 16'd0, 8'd0);
    run_random(680);

    // Mid-range scale and thresholds, with no idling on either side.
    drain_results(1'b1);
    set_config(32'($urandom_range(32'h20_0000, 32'h400_0000)), 16'($urandom_range(200, 4000)),
               16'($urandom_range(5, 300)), 8'($urandom_range(0, 8)));
    steady = 1'b1;
    run_random(1030);
    steady = 1'b0;

    // Back to the power-on values, written explicitly.
    drain_results(1'b1);
    set_config(32'd10237484, 16'd1000, 16'd30, 8'd5);
    run_random(1380);

    // Fully random register values.
    drain_results(1'b1);
    set_config(32'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    run_random(1880);

    drain_results(1'b1);
    $display("Run covered %0d reading beats over %0d register settings:", items_sent,
             settings_used);
    $display("  %0d sessions closed, %0d recalibrations on drift, %0d results outstanding.",
             sessions, recals, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_load_cell_session_weigher_unit OK");
    end else begin
      $display("tb_load_cell_session_weigher_unit NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/lcsw_pkg.sv
rtl/lcsw_div.sv
rtl/lcsw_rank.sv
rtl/load_cell_session_weigher_unit.sv
bench/lcsw_result_checker.sv
bench/tb_load_cell_session_weigher_unit.sv
